/* rtl/dwpf_pkg.sv */
// Shared types, constants and widths of the two-wheel path follower.
package dwpf_pkg;

   // Path store geometry.
   localparam int PATH_DEPTH = 1024;
   localparam int PATH_AW    = $clog2(PATH_DEPTH);
   localparam int PIDX_W     = PATH_AW + 1;

   // Field widths of the transfer payloads.
   localparam int PULSE_W  = 12;
   localparam int SPEED_W  = 16;
   localparam int ENTRY_W  = 10;
   localparam int STEP_W   = 11;
   localparam int DRIVE_W  = 16;

   // Configuration register widths.
   localparam int SPP_W    = 16;
   localparam int FGAIN_W  = 16;
   localparam int PGAIN_W  = 32;
   localparam int IGAIN_W  = 32;
   localparam int PLEN_W   = 11;
   localparam int TPS_W    = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // Datapath widths.
   localparam int SPD_W   = 29;   // scaled encoder speed, mm/s with 8 fraction bits
   localparam int FILT_W  = 32;   // filtered speed
   localparam int SUM_W   = 48;   // saturating error sum
   localparam int ERR_W   = 33;   // speed error
   localparam int MAC_A_W = 34;
   localparam int MAC_B_W = 18;
   localparam int PROD_W  = MAC_A_W + MAC_B_W;
   localparam int ACC_W   = 82;
   localparam int FILT_SHIFT = 16;
   localparam int DRV_SHIFT  = 25;
   localparam int WSTATE_W   = FILT_W + SUM_W;

   localparam logic signed [ACC_W-1:0] FILT_ROUND  = ACC_W'(32'sd32768);
   localparam logic signed [ACC_W-1:0] DRIVE_ROUND = ACC_W'(32'sd16777216);

   // Reset values of the configuration registers.
   localparam logic [SPP_W-1:0]   SPP_RESET   = SPP_W'(6400);
   localparam logic [FGAIN_W-1:0] FGAIN_RESET = FGAIN_W'(26214);
   localparam logic [PGAIN_W-1:0] PGAIN_RESET = PGAIN_W'(27487791);
   localparam logic [IGAIN_W-1:0] IGAIN_RESET = IGAIN_W'(54976);
   localparam logic [PLEN_W-1:0]  PLEN_RESET  = '0;
   localparam logic [TPS_W-1:0]   TPS_RESET   = TPS_W'(5);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SPEED_PER_PULSE = 3'd0,
      CSR_FILTER_GAIN     = 3'd1,
      CSR_PROP_GAIN       = 3'd2,
      CSR_INTEGRAL_GAIN   = 3'd3,
      CSR_PATH_LENGTH     = 3'd4,
      CSR_TICKS_PER_STEP  = 3'd5
   } csr_reg_type;

   localparam logic KIND_TICK = 1'b0;
   localparam logic KIND_LOAD = 1'b1;

   typedef struct packed {
      logic                      kind;
      logic signed [PULSE_W-1:0] pulses_left;
      logic signed [PULSE_W-1:0] pulses_right;
      logic [ENTRY_W-1:0]        entry_index;
      logic signed [SPEED_W-1:0] entry_right_speed;
      logic signed [SPEED_W-1:0] entry_left_speed;
   } req_data_type;

   typedef struct packed {
      logic signed [DRIVE_W-1:0] drive_left;
      logic signed [DRIVE_W-1:0] drive_right;
      logic [STEP_W-1:0]         step_index;
      logic                      path_done;
   } rsp_data_type;

   typedef enum logic [1:0] {
      SH_0  = 2'd0,
      SH_16 = 2'd1,
      SH_32 = 2'd2
   } mac_shift_type;

   // Control of the shared multiply-accumulate unit for one cycle.
   typedef struct packed {
      logic          go;         // form a product this cycle
      logic          init;       // load the accumulator with a rounding constant
      logic          round_sel;  // 0: filter rounding, 1: drive rounding
      mac_shift_type shift;      // weight of this product
   } mac_ctrl_type;

endpackage

/* rtl/dwpf_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module dwpf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/dwpf_mac.sv */
// Shared multiply-accumulate unit: one registered product per cycle, weighted add next cycle.
module dwpf_mac import dwpf_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  mac_ctrl_type              ctrl,
   input  logic signed [MAC_A_W-1:0] op_a,
   input  logic signed [MAC_B_W-1:0] op_b,
   output logic signed [ACC_W-1:0]   acc
);

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   mac_shift_type            shift_ff;
   logic                     add_ff;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [ACC_W-1:0]  prod_ext;
   logic signed [ACC_W-1:0]  addend;

   always_comb begin
      prod_in  = op_a * op_b;
      prod_ext = ACC_W'(prod_ff);
      unique case (shift_ff)
         SH_0:    addend = prod_ext;
         SH_16:   addend = prod_ext <<< 16;
         SH_32:   addend = prod_ext <<< 32;
         default: addend = '0;
      endcase
      if (ctrl.init) begin
         acc_in = ctrl.round_sel ? DRIVE_ROUND : FILT_ROUND;
      end else if (add_ff) begin
         acc_in = acc_ff + addend;
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         add_ff <= 1'b0;
      end else begin
         add_ff <= ctrl.go;
      end
      prod_ff  <= prod_in;
      shift_ff <= ctrl.shift;
      acc_ff   <= acc_in;
   end

   assign acc = acc_ff;

endmodule

/* rtl/dual_wheel_pi_path_follower_core.sv */
// Top level of the two-wheel PI speed regulator that follows a stored velocity path.
// A request transfer is either a load, which writes one entry of the path store and
// produces no response, or a control tick, which produces exactly one response with
// the saturated Q1.15 drives of both wheels, the path index in use and a done flag.
// A load leaves the block idle, so the next request can follow at once. A tick keeps
// the request side busy until its response becomes valid, in the same cycle in
// which the block returns to idle and can take the next request. The length of a
// tick is set by the single multiply-accumulate unit, which forms the seven
// partial products of each wheel (two for the low-pass filter, two for the
// proportional term, three for the integral term) one per cycle, plus the read
// of the wheel state memory and the write-back. The finished response sits in an
// output register, so a new request is taken while an earlier response still
// waits for rsp_ready; a tick that finishes while that register is still full
// waits in its last step for as long as the stall lasts. Configuration writes are
// taken in any cycle but must only be issued while no tick is in work.
// Reading a path entry that was never loaded since reset returns unspecified drives.
module dual_wheel_pi_path_follower_core import dwpf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_data_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_data_type          rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_RD_PATH,
      ST_RD_WHEEL,
      ST_LOAD,
      ST_F0,
      ST_F1,
      ST_FWAIT,
      ST_ERR,
      ST_P0,
      ST_P1,
      ST_P2,
      ST_P3,
      ST_P4,
      ST_PWAIT,
      ST_DRIVE,
      ST_OUT
   } state_type;

   localparam int SUM_X  = SUM_W + 1;
   localparam int SAT_LO = DRV_SHIFT + DRIVE_W - 1;

   // Configuration registers.
   logic [SPP_W-1:0]   spp_ff;
   logic [FGAIN_W-1:0] fgain_ff;
   logic [PGAIN_W-1:0] pgain_ff;
   logic [IGAIN_W-1:0] igain_ff;
   logic [PLEN_W-1:0]  plen_ff;
   logic [TPS_W-1:0]   tps_ff;

   // Control state.
   state_type          state_ff;
   logic               wheel_ff;          // 0 while working on the left wheel
   logic [1:0]         wvalid_ff;         // wheel state entry written since reset
   logic [TPS_W-1:0]   tick_count_ff, tick_in;
   logic [PIDX_W-1:0]  path_index_ff, pidx_in;
   logic               done_ff, done_in;
   logic               rsp_valid_ff;
   rsp_data_type       rsp_data_ff;

   // Datapath registers.
   logic signed [SPD_W-1:0]   spd_left_ff, spd_right_ff, spd_left_in, spd_right_in;
   logic signed [SPEED_W-1:0] tgt_left_ff, tgt_right_ff;
   logic signed [FILT_W-1:0]  filt_ff, filt_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic signed [ERR_W-1:0]   err_ff, err_in;
   logic signed [DRIVE_W-1:0] drive_left_ff, drive_right_ff, drive_in;

   logic                      req_fire;
   logic [PIDX_W-1:0]         eff_len;
   logic                      advance;
   logic signed [SPD_W-1:0]   pl_ext, pr_ext, spp_ext;
   logic signed [SPD_W-1:0]   cur_spd;
   logic signed [SPEED_W-1:0] cur_tgt;
   logic signed [ERR_W-1:0]   tgt_scaled;
   logic signed [SUM_X-1:0]   sum_wide;
   logic [FGAIN_W:0]          gain_comp;

   // Memory ports.
   logic                path_wr_en;
   logic [PATH_AW-1:0]  path_wr_addr;
   logic [2*SPEED_W-1:0] path_wr_data;
   logic                path_rd_en;
   logic [2*SPEED_W-1:0] path_rd_data;
   logic                wheel_rd_en;
   logic                wheel_wr_en;
   logic [WSTATE_W-1:0] wheel_rd_data;

   // Multiply-accumulate unit.
   mac_ctrl_type              mac_ctrl;
   logic signed [MAC_A_W-1:0] mac_a;
   logic signed [MAC_B_W-1:0] mac_b;
   logic signed [ACC_W-1:0]   mac_acc;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Configuration write port; out-of-range indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         spp_ff   <= SPP_RESET;
         fgain_ff <= FGAIN_RESET;
         pgain_ff <= PGAIN_RESET;
         igain_ff <= IGAIN_RESET;
         plen_ff  <= PLEN_RESET;
         tps_ff   <= TPS_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_SPEED_PER_PULSE: spp_ff   <= csr_data[SPP_W-1:0];
            CSR_FILTER_GAIN:     fgain_ff <= csr_data[FGAIN_W-1:0];
            CSR_PROP_GAIN:       pgain_ff <= csr_data[PGAIN_W-1:0];
            CSR_INTEGRAL_GAIN:   igain_ff <= csr_data[IGAIN_W-1:0];
            CSR_PATH_LENGTH:     plen_ff  <= csr_data[PLEN_W-1:0];
            CSR_TICKS_PER_STEP:  tps_ff   <= csr_data[TPS_W-1:0];
            default: ;
         endcase
      end
   end

   // Path stepping for a tick. The effective length is the configured length clipped
   // to the store depth; the index saturates there and stays put if the length shrinks.
   always_comb begin
      if (32'(plen_ff) > PATH_DEPTH) begin
         eff_len = PIDX_W'(PATH_DEPTH);
      end else begin
         eff_len = PIDX_W'(plen_ff);
      end
      advance = (tick_count_ff >= tps_ff);
      if (advance && (path_index_ff < eff_len)) begin
         pidx_in = path_index_ff + 1'b1;
      end else begin
         pidx_in = path_index_ff;
      end
      done_in = (pidx_in >= eff_len);
      tick_in = (advance ? '0 : tick_count_ff) + 1'b1;
   end

   // Encoder counts scaled to speed; the left count is negated because that motor
   // is mounted mirrored.
   always_comb begin
      pl_ext       = SPD_W'(req_data.pulses_left);
      pr_ext       = SPD_W'(req_data.pulses_right);
      spp_ext      = SPD_W'(signed'({1'b0, spp_ff}));
      spd_left_in  = (-pl_ext) * spp_ext;
      spd_right_in = pr_ext * spp_ext;
   end

   // Path store: loads write it while idle, the tick reads it once.
   assign path_wr_en   = req_fire && (req_data.kind == KIND_LOAD) &&
                         (32'(req_data.entry_index) < PATH_DEPTH);
   assign path_wr_addr = PATH_AW'(req_data.entry_index);
   assign path_wr_data = {req_data.entry_left_speed, req_data.entry_right_speed};
   assign path_rd_en   = (state_ff == ST_RD_PATH);

   dwpf_ram #(
      .WIDTH (2 * SPEED_W),
      .DEPTH (PATH_DEPTH)
   ) u_path_ram (
      .clock   (clock),
      .wr_en   (path_wr_en),
      .wr_addr (path_wr_addr),
      .wr_data (path_wr_data),
      .rd_en   (path_rd_en),
      .rd_addr (path_index_ff[PATH_AW-1:0]),
      .rd_data (path_rd_data)
   );

   // Wheel state store: entry 0 is the left wheel, entry 1 the right. Each entry is
   // read, updated and written back before the other is touched, and the next tick
   // starts only after both write-backs, so no forwarding is needed. An entry not yet
   // written reads as zero through its valid bit.
   assign wheel_rd_en = (state_ff == ST_RD_PATH) || (state_ff == ST_RD_WHEEL);
   assign wheel_wr_en = (state_ff == ST_DRIVE);

   dwpf_ram #(
      .WIDTH (WSTATE_W),
      .DEPTH (2)
   ) u_wheel_ram (
      .clock   (clock),
      .wr_en   (wheel_wr_en),
      .wr_addr (wheel_ff),
      .wr_data ({filt_ff, sum_ff}),
      .rd_en   (wheel_rd_en),
      .rd_addr (wheel_ff),
      .rd_data (wheel_rd_data)
   );

   // Operand selection for the multiply-accumulate unit.
   //   filter: acc = 2^15 + g*f + (65536-g)*s, new f = acc >> 16
   //   drive:  acc = 2^24 + kp*e + ki*sum, drive = sat(acc >> 25)
   // The proportional gain and the error sum are split into 16-bit slices so that
   // each product fits the unit.
   always_comb begin
      cur_spd   = wheel_ff ? spd_right_ff : spd_left_ff;
      cur_tgt   = wheel_ff ? tgt_right_ff : tgt_left_ff;
      gain_comp = (FGAIN_W+1)'(32'd65536) - (FGAIN_W+1)'(fgain_ff);
      mac_ctrl  = '{go: 1'b0, init: 1'b0, round_sel: 1'b0, shift: SH_0};
      mac_a     = '0;
      mac_b     = '0;
      unique case (state_ff)
         ST_F0: begin
            mac_ctrl = '{go: 1'b1, init: 1'b1, round_sel: 1'b0, shift: SH_0};
            mac_a    = MAC_A_W'(filt_ff);
            mac_b    = MAC_B_W'(fgain_ff);
         end
         ST_F1: begin
            mac_ctrl = '{go: 1'b1, init: 1'b0, round_sel: 1'b0, shift: SH_0};
            mac_a    = MAC_A_W'(cur_spd);
            mac_b    = MAC_B_W'(gain_comp);
         end
         ST_P0: begin
            mac_ctrl = '{go: 1'b1, init: 1'b1, round_sel: 1'b1, shift: SH_0};
            mac_a    = MAC_A_W'(err_ff);
            mac_b    = MAC_B_W'(pgain_ff[15:0]);
         end
         ST_P1: begin
            mac_ctrl = '{go: 1'b1, init: 1'b0, round_sel: 1'b1, shift: SH_16};
            mac_a    = MAC_A_W'(err_ff);
            mac_b    = MAC_B_W'(pgain_ff[31:16]);
         end
         ST_P2: begin
            mac_ctrl = '{go: 1'b1, init: 1'b0, round_sel: 1'b1, shift: SH_0};
            mac_a    = MAC_A_W'(igain_ff);
            mac_b    = MAC_B_W'(sum_ff[15:0]);
         end
         ST_P3: begin
            mac_ctrl = '{go: 1'b1, init: 1'b0, round_sel: 1'b1, shift: SH_16};
            mac_a    = MAC_A_W'(igain_ff);
            mac_b    = MAC_B_W'(sum_ff[31:16]);
         end
         ST_P4: begin
            // The top slice carries the sign of the error sum.
            mac_ctrl = '{go: 1'b1, init: 1'b0, round_sel: 1'b1, shift: SH_32};
            mac_a    = MAC_A_W'(igain_ff);
            mac_b    = MAC_B_W'(signed'(sum_ff[47:32]));
         end
         default: ;
      endcase
   end

   dwpf_mac u_mac (
      .clock (clock),
      .reset (reset),
      .ctrl  (mac_ctrl),
      .op_a  (mac_a),
      .op_b  (mac_b),
      .acc   (mac_acc)
   );

   // Filter result, speed error and saturating error sum, all from the settled
   // filter accumulation.
   always_comb begin
      filt_in    = mac_acc[FILT_SHIFT+FILT_W-1:FILT_SHIFT];
      tgt_scaled = ERR_W'(cur_tgt) <<< 8;
      err_in     = tgt_scaled - ERR_W'(filt_in);
      sum_wide   = SUM_X'(sum_ff) + SUM_X'(err_in);
      if (sum_wide[SUM_X-1] != sum_wide[SUM_X-2]) begin
         sum_in = sum_wide[SUM_X-1] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
         sum_in = sum_wide[SUM_W-1:0];
      end
   end

   // Drive saturation: the shifted sum fits Q1.15 only if every bit above the
   // result's sign bit repeats it.
   always_comb begin
      if (mac_acc[ACC_W-1:SAT_LO] == {(ACC_W-SAT_LO){mac_acc[SAT_LO]}}) begin
         drive_in = mac_acc[SAT_LO:DRV_SHIFT];
      end else if (mac_acc[ACC_W-1]) begin
         drive_in = {1'b1, {(DRIVE_W-1){1'b0}}};
      end else begin
         drive_in = {1'b0, {(DRIVE_W-1){1'b1}}};
      end
   end

   // Sequencer, path bookkeeping and response register. In the last step of a tick
   // the response register is loaded when it is empty or its transfer happens now,
   // so the valid flag is only cleared here in other states.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         wheel_ff      <= 1'b0;
         wvalid_ff     <= '0;
         tick_count_ff <= '0;
         path_index_ff <= '0;
         done_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire && (req_data.kind == KIND_TICK)) begin
                  tick_count_ff <= tick_in;
                  path_index_ff <= pidx_in;
                  done_ff       <= done_in;
                  wheel_ff      <= 1'b0;
                  state_ff      <= ST_RD_PATH;
               end
            end
            ST_RD_PATH:  state_ff <= ST_LOAD;
            ST_RD_WHEEL: state_ff <= ST_LOAD;
            ST_LOAD:     state_ff <= ST_F0;
            ST_F0:       state_ff <= ST_F1;
            ST_F1:       state_ff <= ST_FWAIT;
            ST_FWAIT:    state_ff <= ST_ERR;
            ST_ERR:      state_ff <= ST_P0;
            ST_P0:       state_ff <= ST_P1;
            ST_P1:       state_ff <= ST_P2;
            ST_P2:       state_ff <= ST_P3;
            ST_P3:       state_ff <= ST_P4;
            ST_P4:       state_ff <= ST_PWAIT;
            ST_PWAIT:    state_ff <= ST_DRIVE;
            ST_DRIVE: begin
               wvalid_ff[wheel_ff] <= 1'b1;
               if (!wheel_ff) begin
                  wheel_ff <= 1'b1;
                  state_ff <= ST_RD_WHEEL;
               end else begin
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff           <= 1'b1;
                  rsp_data_ff.drive_left  <= drive_left_ff;
                  rsp_data_ff.drive_right <= drive_right_ff;
                  rsp_data_ff.step_index  <= STEP_W'(path_index_ff);
                  rsp_data_ff.path_done   <= done_ff;
                  state_ff               <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         spd_left_ff  <= spd_left_in;
         spd_right_ff <= spd_right_in;
      end
      if (state_ff == ST_LOAD) begin
         if (!wheel_ff) begin
            // Past the end of the path both targets are zero.
            tgt_left_ff  <= done_ff ? '0 : path_rd_data[2*SPEED_W-1:SPEED_W];
            tgt_right_ff <= done_ff ? '0 : path_rd_data[SPEED_W-1:0];
         end
         filt_ff <= wvalid_ff[wheel_ff] ? wheel_rd_data[WSTATE_W-1:SUM_W] : '0;
         sum_ff  <= wvalid_ff[wheel_ff] ? wheel_rd_data[SUM_W-1:0] : '0;
      end
      if (state_ff == ST_ERR) begin
         filt_ff <= filt_in;
         err_ff  <= err_in;
         sum_ff  <= sum_in;
      end
      if (state_ff == ST_DRIVE) begin
         if (!wheel_ff) begin
            drive_left_ff <= drive_in;
         end else begin
            drive_right_ff <= drive_in;
         end
      end
   end

endmodule

/* rtl/dwpf_checker.sv */
// Port-level checker for the path follower core and its bind to the top level.
module dwpf_checker import dwpf_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input req_data_type          req_data,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input rsp_data_type          rsp_data,
   input logic                  csr_valid,
   input logic                  csr_ready,
   input logic [CSR_IDX_W-1:0]  csr_index,
   input logic [CSR_DATA_W-1:0] csr_data
);

   // A response waiting for the consumer holds still.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
   else $error("response changed while stalled");

   // A tick transfer occupies the block: no request is taken in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_data.kind == KIND_TICK) |=> !req_ready)
   else $error("request taken while a tick is in work");

   // A response never appears right after a request transfer; loads produce none
   // and ticks take many cycles.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_valid && req_ready))
   else $error("response directly after a request transfer");

   // While the path is not done, the index points into the store.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.path_done |-> rsp_data.step_index < STEP_W'(PATH_DEPTH))
   else $error("step index beyond the path store while not done");

endmodule

bind dual_wheel_pi_path_follower_core dwpf_checker u_dwpf_checker (.*);

/* sim/testbench.sv */
// Self-checking testbench for the two-wheel PI path follower core.
`timescale 1ns / 1ps

// The bench runs a short table of directed requests, then several phases of
// random traffic, each under its own register setting. Every accepted tick is
// run through a bit-accurate drive predictor kept in this file, and the
// predicted response is queued. Each response transfer is checked field by
// field against the oldest queued prediction. The request side sends in bursts
// with random gaps, and the response side stalls on a pattern of its own.
module testbench import dwpf_pkg::*;;

   // Wide signed type for the predictor. The integral product needs about 81 bits.
   typedef logic signed [95:0] wide_type;

   localparam int       CYCLE_LIMIT   = 600000;
   localparam int       SETTLE_CYCLES = 40;
   localparam int       MAX_PRINTED   = 30;
   localparam wide_type SUM_MAX       = (wide_type'(1) <<< 47) - 1;
   localparam wide_type SUM_MIN       = -(wide_type'(1) <<< 47);
   localparam wide_type DRIVE_HALF    = wide_type'(1) <<< 24;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_RANDOM,
      READY_PERIODIC
   } ready_mode_type;

   // One row of the directed table. Where fixed is set, the response is typed in.
   typedef struct {
      req_data_type item;
      bit           fixed;
      rsp_data_type fixed_rsp;
   } stimulus_row_type;

   // One register setting and the number of random requests run under it.
   typedef struct {
      logic [SPP_W-1:0]   spp;
      logic [FGAIN_W-1:0] fgain;
      logic [PGAIN_W-1:0] pgain;
      logic [IGAIN_W-1:0] igain;
      logic [PLEN_W-1:0]  plen;
      logic [TPS_W-1:0]   tps;
      int                 items;
   } setting_type;

   logic                  clock;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_data_type          req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_data_type          rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data  = '0;

   dual_wheel_pi_path_follower_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // 20 ns clock period.
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Predictor copy of the registers, starting from their reset values.
   logic [SPP_W-1:0]   spp_cfg   = SPP_RESET;
   logic [FGAIN_W-1:0] fgain_cfg = FGAIN_RESET;
   logic [PGAIN_W-1:0] pgain_cfg = PGAIN_RESET;
   logic [IGAIN_W-1:0] igain_cfg = IGAIN_RESET;
   logic [PLEN_W-1:0]  plen_cfg  = PLEN_RESET;
   logic [TPS_W-1:0]   tps_cfg   = TPS_RESET;

   // Predictor copy of the regulator state. The path store keeps a written flag
   // per entry so that the stimulus never makes the block read an unloaded entry.
   logic signed [FILT_W-1:0] filt_left   = '0;
   logic signed [FILT_W-1:0] filt_right  = '0;
   logic signed [SUM_W-1:0]  integ_left  = '0;
   logic signed [SUM_W-1:0]  integ_right = '0;
   logic [TPS_W-1:0]         tick_cnt    = '0;
   logic [PIDX_W-1:0]        path_pos    = '0;
   logic [31:0]              path_mem    [PATH_DEPTH];
   bit                       path_loaded [PATH_DEPTH];

   rsp_data_type pending_drives[$];
   rsp_data_type oldest_drive;

   int             error_count    = 0;
   int             cycle_count    = 0;
   int             responses_seen = 0;
   int             ticks_sent     = 0;
   int             loads_sent     = 0;
   int             burst_left     = 0;
   ready_mode_type ready_mode     = READY_ALWAYS;
   int             mode_left      = 0;
   int             stall_period   = 2;
   int             stall_phase    = 0;

   // Every mismatch goes through here: one printed line, and the count goes up.
   // Printing stops after a while so that a broken block cannot flood the log.
   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= MAX_PRINTED)
         $display("MISMATCH at cycle %0d: %s", cycle_count, what);
   endtask

   function automatic logic [PIDX_W-1:0] effective_length();
      return (plen_cfg < PIDX_W'(PATH_DEPTH)) ? plen_cfg : PIDX_W'(PATH_DEPTH);
   endfunction

   // One wheel of the regulator: low-pass filter, error, saturating error sum,
   // and the PI drive. All terms are formed at full width and rounded once, so
   // the arithmetic shifts give floor division exactly.
   function automatic logic signed [DRIVE_W-1:0] wheel_drive(
      input  wide_type                  speed,
      input  logic signed [SPEED_W-1:0] target,
      inout  logic signed [FILT_W-1:0]  filt,
      inout  logic signed [SUM_W-1:0]   integ
   );
      wide_type gain;
      wide_type smooth;
      wide_type err;
      wide_type total;
      wide_type drive;
      gain   = wide_type'(fgain_cfg);
      smooth = (gain * wide_type'(filt) + (wide_type'(65536) - gain) * speed
                + wide_type'(32768)) >>> FILT_SHIFT;
      err    = wide_type'(target) * wide_type'(256) - smooth;
      total  = wide_type'(integ) + err;
      if (total > SUM_MAX)
         total = SUM_MAX;
      if (total < SUM_MIN)
         total = SUM_MIN;
      filt  = smooth[FILT_W-1:0];
      integ = total[SUM_W-1:0];
      drive = (wide_type'(pgain_cfg) * err + wide_type'(igain_cfg) * total + DRIVE_HALF)
              >>> DRV_SHIFT;
      if (drive > wide_type'(32767))
         return 16'sh7FFF;
      if (drive < wide_type'(-32768))
         return 16'sh8000;
      return drive[DRIVE_W-1:0];
   endfunction

   // Advances the predictor by one tick and returns the response it must give.
   // The index moves first (when the hold count has run out), then the targets
   // are read, and the hold count goes up after the drives are formed.
   function automatic rsp_data_type compute_drives(input req_data_type item);
      rsp_data_type              result;
      logic [PIDX_W-1:0]         eff;
      wide_type                  rate_left;
      wide_type                  rate_right;
      logic signed [SPEED_W-1:0] target_left;
      logic signed [SPEED_W-1:0] target_right;
      eff        = effective_length();
      // The left encoder counts backward, so its pulses are negated.
      rate_left  = -(wide_type'(item.pulses_left) * wide_type'(spp_cfg));
      rate_right = wide_type'(item.pulses_right) * wide_type'(spp_cfg);
      if (tick_cnt >= tps_cfg) begin
         tick_cnt = '0;
         if (path_pos < eff)
            path_pos = path_pos + 1'b1;
      end
      result.path_done = (path_pos >= eff);
      target_left      = '0;
      target_right     = '0;
      if (!result.path_done) begin
         target_right = path_mem[path_pos[PATH_AW-1:0]][15:0];
         target_left  = path_mem[path_pos[PATH_AW-1:0]][31:16];
      end
      result.drive_left  = wheel_drive(rate_left, target_left, filt_left, integ_left);
      result.drive_right = wheel_drive(rate_right, target_right, filt_right, integ_right);
      result.step_index  = path_pos;
      tick_cnt           = tick_cnt + 1'b1;
      return result;
   endfunction

   // Path index that the next tick will use, without touching the state.
   function automatic logic [PIDX_W-1:0] upcoming_step(output bit done);
      logic [PIDX_W-1:0] eff;
      logic [PIDX_W-1:0] pos;
      eff = effective_length();
      pos = path_pos;
      if (tick_cnt >= tps_cfg && pos < eff)
         pos = pos + 1'b1;
      done = (pos >= eff);
      return pos;
   endfunction

   // A tick carries random values in the load fields so that those bits toggle
   // on ticks as well.
   function automatic req_data_type tick_item(input logic signed [PULSE_W-1:0] left,
                                              input logic signed [PULSE_W-1:0] right);
      req_data_type item;
      item.kind              = KIND_TICK;
      item.pulses_left       = left;
      item.pulses_right      = right;
      item.entry_index       = ENTRY_W'($urandom);
      item.entry_right_speed = SPEED_W'($urandom);
      item.entry_left_speed  = SPEED_W'($urandom);
      return item;
   endfunction

   function automatic req_data_type load_item(input logic [ENTRY_W-1:0] index,
                                              input logic signed [SPEED_W-1:0] right,
                                              input logic signed [SPEED_W-1:0] left);
      req_data_type item;
      item.kind              = KIND_LOAD;
      item.pulses_left       = PULSE_W'($urandom);
      item.pulses_right      = PULSE_W'($urandom);
      item.entry_index       = index;
      item.entry_right_speed = right;
      item.entry_left_speed  = left;
      return item;
   endfunction

   // Mostly the small counts of a real wheel, sometimes anything the field holds.
   function automatic logic signed [PULSE_W-1:0] random_pulses();
      logic signed [PULSE_W-1:0] value;
      if ($urandom_range(0, 3) == 0)
         return PULSE_W'($urandom);
      value = PULSE_W'($urandom_range(0, 300));
      return value - 12'sd150;
   endfunction

   function automatic logic signed [SPEED_W-1:0] random_speed();
      logic signed [SPEED_W-1:0] value;
      if ($urandom_range(0, 3) == 0)
         return SPEED_W'($urandom);
      value = SPEED_W'($urandom_range(0, 4000));
      return value - 16'sd2000;
   endfunction

   function automatic setting_type make_setting(input logic [SPP_W-1:0] spp,
                                                input logic [FGAIN_W-1:0] fgain,
                                                input logic [PGAIN_W-1:0] pgain,
                                                input logic [IGAIN_W-1:0] igain,
                                                input logic [PLEN_W-1:0] plen,
                                                input logic [TPS_W-1:0] tps,
                                                input int items);
      setting_type s;
      s.spp   = spp;
      s.fgain = fgain;
      s.pgain = pgain;
      s.igain = igain;
      s.plen  = plen;
      s.tps   = tps;
      s.items = items;
      return s;
   endfunction

   // Sends one request and books it once the transfer has happened. The sender
   // works in bursts: when a burst runs out, valid drops for a random gap. Valid
   // stays high between back-to-back requests of one burst, and only the
   // payload changes. A load updates the path store of the predictor, a tick
   // queues its predicted response (or the typed-in one of a directed row).
   task automatic issue_request(input req_data_type item, input bit fixed,
                                input rsp_data_type fixed_rsp);
      rsp_data_type predicted;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 40)) @(posedge clock);
         // Now and then a long burst gives a stretch with no idling at all.
         burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 16);
      end
      req_data  <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      burst_left--;
      if (item.kind == KIND_LOAD) begin
         path_mem[item.entry_index]    = {item.entry_left_speed, item.entry_right_speed};
         path_loaded[item.entry_index] = 1'b1;
         loads_sent++;
      end else begin
         predicted = compute_drives(item);
         pending_drives.push_back(fixed ? fixed_rsp : predicted);
         ticks_sent++;
      end
   endtask

   // Lets the block go quiet: no request offered, every predicted response
   // received, and a margin for any load or tick still inside the pipeline.
   task automatic wait_idle();
      req_valid  <= 1'b0;
      burst_left = 0;
      while (pending_drives.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write. Valid is lowered for a cycle between writes.
   task automatic write_csr(input csr_reg_type index, input logic [CSR_DATA_W-1:0] value);
      csr_index <= index;
      csr_data  <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
      case (index)
         CSR_SPEED_PER_PULSE: spp_cfg   = value[SPP_W-1:0];
         CSR_FILTER_GAIN:     fgain_cfg = value[FGAIN_W-1:0];
         CSR_PROP_GAIN:       pgain_cfg = value[PGAIN_W-1:0];
         CSR_INTEGRAL_GAIN:   igain_cfg = value[IGAIN_W-1:0];
         CSR_PATH_LENGTH:     plen_cfg  = value[PLEN_W-1:0];
         CSR_TICKS_PER_STEP:  tps_cfg   = value[TPS_W-1:0];
         default: ;
      endcase
   endtask

   // Random traffic. Most requests are ticks, and a tick whose path entry has
   // not been loaded yet is preceded by a load of that entry, so the path is
   // always followed through valid data. The remaining requests are loads,
   // half near the current index and half anywhere in the store.
   task automatic run_random(input int count);
      logic [PIDX_W-1:0] step;
      bit                done;
      int                index;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 9) < 7) begin
            step = upcoming_step(done);
            if (!done && !path_loaded[step[PATH_AW-1:0]])
               issue_request(load_item(step[PATH_AW-1:0], random_speed(), random_speed()),
                             1'b0, '0);
            issue_request(tick_item(random_pulses(), random_pulses()), 1'b0, '0);
         end else begin
            index = int'(path_pos) + $urandom_range(0, 6);
            if (index >= PATH_DEPTH || $urandom_range(0, 1) == 0)
               index = $urandom_range(0, PATH_DEPTH - 1);
            issue_request(load_item(ENTRY_W'(index), random_speed(), random_speed()),
                          1'b0, '0);
         end
      end
   endtask

   // Response side: a transfer is checked against the oldest prediction, then
   // the ready for the next edge is chosen. The stall pattern switches now and
   // then among always ready, coin-flip ready, and periodic ready with a random
   // period, so stalls land on every part of a tick.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         responses_seen++;
         if (pending_drives.size() == 0) begin
            report_mismatch("response transfer with no tick waiting for it");
         end else begin
            oldest_drive = pending_drives.pop_front();
            if (rsp_data.drive_left !== oldest_drive.drive_left)
               report_mismatch($sformatf("drive_left got %0d, predicted %0d",
                                         rsp_data.drive_left, oldest_drive.drive_left));
            if (rsp_data.drive_right !== oldest_drive.drive_right)
               report_mismatch($sformatf("drive_right got %0d, predicted %0d",
                                         rsp_data.drive_right, oldest_drive.drive_right));
            if (rsp_data.step_index !== oldest_drive.step_index)
               report_mismatch($sformatf("step_index got %0d, predicted %0d",
                                         rsp_data.step_index, oldest_drive.step_index));
            if (rsp_data.path_done !== oldest_drive.path_done)
               report_mismatch($sformatf("path_done got %0b, predicted %0b",
                                         rsp_data.path_done, oldest_drive.path_done));
         end
      end
      if (mode_left == 0) begin
         ready_mode   = ready_mode_type'($urandom_range(0, 2));
         mode_left    = $urandom_range(50, 300);
         stall_period = $urandom_range(2, 40);
         stall_phase  = 0;
      end else begin
         mode_left--;
      end
      case (ready_mode)
         READY_ALWAYS: rsp_ready <= 1'b1;
         READY_RANDOM: rsp_ready <= 1'($urandom_range(0, 1));
         default: begin
            rsp_ready   <= (stall_phase == 0);
            stall_phase = (stall_phase + 1) % stall_period;
         end
      endcase
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      stimulus_row_type directed_rows[$];
      setting_type      settings[$];
      rsp_data_type     idle_rsp;

      // Right after reset the path is empty, so a still wheel gets zero drive
      // at index 0 with the path already done.
      idle_rsp           = '0;
      idle_rsp.path_done = 1'b1;

      // Directed part, under the reset register values. Loads at both ends of
      // the store with extreme speeds, and ticks with extreme pulse counts in
      // both directions. The path entries loaded here are read in later phases.
      directed_rows.push_back('{tick_item(12'sd0, 12'sd0), 1'b1, idle_rsp});
      directed_rows.push_back('{tick_item(12'sd0, 12'sd0), 1'b1, idle_rsp});
      directed_rows.push_back('{load_item(10'd0, 16'sh7FFF, -16'sh8000), 1'b0, '0});
      directed_rows.push_back('{load_item(10'd1023, -16'sh8000, 16'sh7FFF), 1'b0, '0});
      directed_rows.push_back('{load_item(10'd1, -16'sd1, 16'sd1), 1'b0, '0});
      directed_rows.push_back('{load_item(10'd2, 16'sd0, 16'sd0), 1'b0, '0});
      directed_rows.push_back('{tick_item(12'sd2047, -12'sd2048), 1'b0, '0});
      directed_rows.push_back('{tick_item(-12'sd2048, 12'sd2047), 1'b0, '0});
      directed_rows.push_back('{tick_item(12'sd2047, 12'sd2047), 1'b0, '0});
      directed_rows.push_back('{tick_item(-12'sd2048, -12'sd2048), 1'b0, '0});
      directed_rows.push_back('{load_item(10'd341, 16'sh5555, -16'sh5556), 1'b0, '0});
      directed_rows.push_back('{load_item(10'd682, -16'sh5556, 16'sh5555), 1'b0, '0});
      directed_rows.push_back('{tick_item(-12'sd1, 12'sd1), 1'b0, '0});
      directed_rows.push_back('{tick_item(12'sd0, 12'sd0), 1'b0, '0});
      directed_rows.push_back('{tick_item(12'sd1, -12'sd1), 1'b0, '0});
      directed_rows.push_back('{load_item(10'd3, 16'sd1000, 16'sd1000), 1'b0, '0});
      directed_rows.push_back('{tick_item(12'sd0, 12'sd0), 1'b0, '0});
      directed_rows.push_back('{tick_item(12'sd0, 12'sd0), 1'b0, '0});

      // Register settings for the random phases, in order:
      // a short path stepped every tick; the largest gains and scale with no
      // filtering; a path cut below the current index with zero ticks per step,
      // so the index holds and the path stays done; the full store with the
      // longest hold, zero scale and zero PI gains; two random settings, the second
      // over the full store stepped on every tick; and the reset gains again.
      settings.push_back(make_setting(SPP_RESET, FGAIN_RESET, PGAIN_RESET, IGAIN_RESET,
                                      11'd12, 8'd1, 70));
      settings.push_back(make_setting(16'hFFFF, 16'h0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                      11'd40, 8'd3, 80));
      settings.push_back(make_setting(16'd3000, 16'd40000, 32'd60000000, 32'd200000,
                                      11'd5, 8'd0, 55));
      settings.push_back(make_setting(16'h0000, 16'hFFFF, 32'h0, 32'h0,
                                      11'd1024, 8'd255, 60));
      settings.push_back(make_setting(SPP_W'($urandom), FGAIN_W'($urandom), $urandom,
                                      $urandom, PLEN_W'($urandom_range(0, 1024)),
                                      TPS_W'($urandom_range(1, 255)), 80));
      settings.push_back(make_setting(SPP_W'($urandom), FGAIN_W'($urandom), $urandom,
                                      IGAIN_W'($urandom_range(0, 1 << 20)), 11'd1024,
                                      8'd0, 60));
      settings.push_back(make_setting(SPP_RESET, FGAIN_RESET, PGAIN_RESET, IGAIN_RESET,
                                      11'd300, 8'd1, 60));

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         issue_request(directed_rows[i].item, directed_rows[i].fixed,
                       directed_rows[i].fixed_rsp);

      // Registers change only while the block is idle.
      foreach (settings[i]) begin
         wait_idle();
         write_csr(CSR_SPEED_PER_PULSE, CSR_DATA_W'(settings[i].spp));
         write_csr(CSR_FILTER_GAIN, CSR_DATA_W'(settings[i].fgain));
         write_csr(CSR_PROP_GAIN, settings[i].pgain);
         write_csr(CSR_INTEGRAL_GAIN, settings[i].igain);
         write_csr(CSR_PATH_LENGTH, CSR_DATA_W'(settings[i].plen));
         write_csr(CSR_TICKS_PER_STEP, CSR_DATA_W'(settings[i].tps));
         run_random(settings[i].items);
      end

      // Every prediction has been matched by now; the margin catches a stray
      // response that would come after the last expected one.
      wait_idle();

      $display("Ran %0d ticks and %0d path loads under %0d register settings.",
               ticks_sent, loads_sent, settings.size() + 1);
      $display("Checked %0d responses, %0d field mismatches, final path index %0d.",
               responses_seen, error_count, path_pos);
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
